FILE: sv/trimmed_mean_sample_filter_top_macros.svh
`ifndef TRIMMED_MEAN_SAMPLE_FILTER_TOP_MACROS_SVH
`define TRIMMED_MEAN_SAMPLE_FILTER_TOP_MACROS_SVH

// Same-cycle implication, gated by reset.
`define TMSF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by reset.
`define TMSF_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tmsf_pkg.sv
package tmsf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 4;
    // quotient always fits in one sample width
    localparam int QSTEPS   = SAMPLE_W;
    localparam int STEP_W   = $clog2(QSTEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_TRIM_HI,
        ST_TRIM_LO,
        ST_DIV,
        ST_FIN
    } tmsf_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: sv/tmsf_if.sv
interface tmsf_sample_if;
    logic                          valid;
    logic                          ready;
    logic [tmsf_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tmsf_filtered_if;
    logic                          valid;
    logic                          ready;
    logic [tmsf_pkg::SAMPLE_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

FILE: sv/trimmed_mean_sample_filter_top.sv
// Trimmed-mean sample filter.
// samples: one 16-bit sample per transfer (valid/ready). results: one 16-bit
// filtered value per accepted sample, in order.
// cfg_we/cfg_data write the 4-bit window setting; write it only while idle.
//   0: pass-through, 1: mean of sample and newest stored sample,
//   N>=2 (clamped to MAX_WINDOW): drop one max and one min of the sample and
//   N stored samples, floored mean of the rest.
// One sample at a time; ready is high only while the sequencer is idle.
// From accept to the earliest result transfer, with the slot free, a sample
// goes through: setting 0: straight to the output register; setting 1: the
// history walk through the shared adder, then the output register; N>=2: the
// history walk, two trim subtracts, the bit-serial divider, then the handoff
// to the output register. Valid rises in the cycle before that transfer.
// The next sample is taken on the edge of that earliest transfer.
// A finished result sits in the output register; the next
// sample is taken meanwhile, and the one after waits until the receiver
// drains the slot.
// Reset clears the history to zero, the setting to 0 and the output slot.
`include "trimmed_mean_sample_filter_top_macros.svh"

module trimmed_mean_sample_filter_top #(
    parameter int MAX_WINDOW = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [tmsf_pkg::CFG_W-1:0] cfg_data,
    tmsf_sample_if.sink                samples,
    tmsf_filtered_if.source            results
);
    import tmsf_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int DV_W  = $clog2(MAX_WINDOW);
    localparam int SUM_W = SAMPLE_W + CNT_W;

    tmsf_state_t         state_reg, state_next;
    logic [CFG_W-1:0]    window_setting_reg;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] hi_reg, hi_next;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [SAMPLE_W-1:0] x_reg, x_next;
    logic [SAMPLE_W-1:0] res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] filtered_reg, filtered_next;
    logic [SAMPLE_W-1:0] hist_reg [MAX_WINDOW];

    logic [CNT_W-1:0]    n_eff;
    logic [SAMPLE_W-1:0] hv;
    logic [SUM_W-1:0]    alu_b;
    logic                alu_sub;
    logic [SUM_W-1:0]    alu_res;
    logic                out_free;
    logic                commit;
    logic                div_start;
    logic [DV_W-1:0]     divisor;
    div_stat_t           div_stat;
    logic [SAMPLE_W-1:0] quotient;

    assign n_eff = (32'(window_setting_reg) > 32'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
                                                               : CNT_W'(window_setting_reg);
    assign hv       = hist_reg[cnt_reg[IDX_W-1:0]];
    assign out_free = !out_valid_reg || results.ready;
    assign samples.ready = (state_reg == ST_IDLE);

    // shared adder: accumulate during the walk, subtract max then min
    always_comb
    begin
        alu_sub = 1'b1;
        case (state_reg)
            ST_ACC:
            begin
                alu_b   = SUM_W'(hv);
                alu_sub = 1'b0;
            end
            ST_TRIM_HI: alu_b = SUM_W'(hi_reg);
            default:    alu_b = SUM_W'(lo_reg);
        endcase
        alu_res = alu_sub ? (sum_reg - alu_b) : (sum_reg + alu_b);
    end

    assign div_start = (state_reg == ST_TRIM_LO);
    assign divisor   = DV_W'(n_reg - 1'b1);

    tmsf_div #(
        .SUM_W (SUM_W),
        .DV_W  (DV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (alu_res),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !results.ready;
        filtered_next  = filtered_reg;
        commit         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    n_next   = n_eff;
                    cnt_next = '0;
                    sum_next = SUM_W'(samples.sample);
                    hi_next  = samples.sample;
                    lo_next  = samples.sample;
                    x_next   = samples.sample;
                    res_next = samples.sample;
                    state_next = (n_eff == '0) ? ST_FIN : ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (cnt_reg == n_reg)
                begin
                    if (n_reg == CNT_W'(1))
                    begin
                        res_next   = sum_reg[SAMPLE_W:1];
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_TRIM_HI;
                    end
                end
                else
                begin
                    sum_next = alu_res;
                    if (hv > hi_reg)
                    begin
                        hi_next = hv;
                    end
                    if (hv < lo_reg)
                    begin
                        lo_next = hv;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_TRIM_HI:
            begin
                sum_next   = alu_res;
                state_next = ST_TRIM_LO;
            end
            ST_TRIM_LO:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    res_next   = quotient;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    filtered_next  = res_reg;
                    commit         = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            window_setting_reg <= '0;
            out_valid_reg      <= 1'b0;
            n_reg              <= '0;
            cnt_reg            <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                window_setting_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        x_reg        <= x_next;
        res_reg      <= res_next;
        filtered_reg <= filtered_next;
    end

    // history shifts below the window only; entry 0 takes the new sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (commit && (n_reg != '0))
        begin
            hist_reg[0] <= x_reg;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                if (CNT_W'(i) < n_reg)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
            end
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.filtered = filtered_reg;

    `TMSF_ASSERT_IMP(a_hi_ge_lo, state_reg == ST_ACC, hi_reg >= lo_reg, "max below min")
    `TMSF_ASSERT_IMP(a_walk_bound, state_reg == ST_ACC, cnt_reg <= n_reg, "walk past window")
    `TMSF_ASSERT_IMP(a_div_done_state, div_stat.done, state_reg == ST_DIV, "stray divider result")
    `TMSF_ASSERT_IMP(a_div_window, div_start, n_reg >= CNT_W'(2), "division with short window")

endmodule

FILE: sv/tmsf_div.sv
`include "trimmed_mean_sample_filter_top_macros.svh"

module tmsf_div #(
    parameter int SUM_W = 20,
    parameter int DV_W  = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              dividend,
    input  logic [DV_W-1:0]               divisor,
    output tmsf_pkg::div_stat_t           stat,
    output logic [tmsf_pkg::SAMPLE_W-1:0] quotient
);
    import tmsf_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DV_W-1:0]     rem_reg,  rem_next;
    logic [SAMPLE_W-1:0] quo_reg,  quo_next;

    logic [DV_W:0]       trial;
    logic [DV_W:0]       diff;
    logic                ge;
    logic [SUM_W-1:0]    divisor_ext;

    assign divisor_ext = SUM_W'(divisor);

    // restoring division, one quotient bit per cycle; the partial remainder
    // starts with the bits above the sample width (they are below the divisor)
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SAMPLE_W-1]};
        ge        = (trial >= {1'b0, divisor});
        diff      = trial - {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(QSTEPS - 1);
            rem_next  = DV_W'(dividend >> SAMPLE_W);
            quo_next  = dividend[SAMPLE_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
            quo_next = {quo_reg[SAMPLE_W-2:0], ge};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    `TMSF_ASSERT_IMP(a_div_fits, start, (dividend >> SAMPLE_W) < divisor_ext, "quotient overflow")
    `TMSF_ASSERT_IMP(a_div_start_idle, start, !busy_reg, "divider restarted while busy")
    `TMSF_ASSERT_NXT(a_div_busy, start, busy_reg && !done_reg, "divider did not start")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import tmsf_pkg::*;

    localparam int MAX_WIN = 8;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    tmsf_sample_if   samples_ch ();
    tmsf_filtered_if results_ch ();

    trimmed_mean_sample_filter_top #(
        .MAX_WINDOW (MAX_WIN)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .samples  (samples_ch),
        .results  (results_ch)
    );

    always #2 clk = ~clk;

    // shadow copy of the filter state
    logic [CFG_W-1:0]    window_cfg = '0;
    logic [SAMPLE_W-1:0] hist [MAX_WIN];

    logic [SAMPLE_W-1:0] pending_samples [$];
    logic [SAMPLE_W-1:0] expected_filtered [$];
    int unsigned         issued_count   = 0;
    int unsigned         accepted_count = 0;
    int unsigned         fail_count     = 0;
    logic                sample_taken   = 1'b0;
    logic                throttle       = 1'b1;
    int unsigned         hold_requests  = 0;
    int unsigned         hold_taken     = 0;
    int unsigned         hold_left      = 0;

    initial begin
        for (int i = 0; i < MAX_WIN; i++)
        begin
            hist[i] = '0;
        end
    end

    function automatic logic [SAMPLE_W-1:0] trimmed_mean(input logic [SAMPLE_W-1:0] smp);
        int unsigned n;
        int unsigned sum;
        int unsigned hi;
        int unsigned lo;
        int unsigned q;
        n = 32'(window_cfg);
        if (n > MAX_WIN)
        begin
            n = MAX_WIN;
        end
        if (n == 0)
        begin
            return smp;
        end
        if (n == 1)
        begin
            q = (32'(hist[0]) + 32'(smp)) >> 1;
            hist[0] = smp;
            return q[SAMPLE_W-1:0];
        end
        sum = 32'(smp);
        hi  = 32'(smp);
        lo  = 32'(smp);
        for (int i = 0; i < n; i++)
        begin
            sum += 32'(hist[i]);
            if (32'(hist[i]) > hi)
            begin
                hi = 32'(hist[i]);
            end
            if (32'(hist[i]) < lo)
            begin
                lo = 32'(hist[i]);
            end
        end
        // one copy each of max and min dropped, even on ties
        q = (sum - hi - lo) / (n - 1);
        for (int i = n - 1; i > 0; i--)
        begin
            hist[i] = hist[i-1];
        end
        hist[0] = smp;
        return q[SAMPLE_W-1:0];
    endfunction

    // monitor: config shadow, input transfers, result checks
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                window_cfg = cfg_data;
            end
            sample_taken <= samples_ch.valid && samples_ch.ready;
            if (samples_ch.valid && samples_ch.ready)
            begin
                expected_filtered.push_back(trimmed_mean(samples_ch.sample));
                accepted_count++;
            end
            if (results_ch.valid && results_ch.ready)
            begin
                if (expected_filtered.size() == 0)
                begin
                    $error("filtered: no result expected, actual %h", results_ch.filtered);
                    fail_count++;
                end
                else
                begin
                    logic [SAMPLE_W-1:0] want;
                    want = expected_filtered.pop_front();
                    if (results_ch.filtered !== want)
                    begin
                        $error("filtered mismatch: expected %h, actual %h",
                               want, results_ch.filtered);
                        fail_count++;
                    end
                end
            end
        end
    end

    // sample driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            samples_ch.valid <= 1'b0;
        end
        else if (!samples_ch.valid || sample_taken)
        begin
            if (pending_samples.size() != 0 && !(throttle && $urandom_range(99) < 33))
            begin
                samples_ch.sample <= pending_samples.pop_front();
                samples_ch.valid  <= 1'b1;
            end
            else
            begin
                samples_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            results_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left        <= hold_left - 1;
            results_ch.ready <= 1'b0;
        end
        else if (hold_taken != hold_requests)
        begin
            hold_taken       <= hold_taken + 1;
            hold_left        <= 300;
            results_ch.ready <= 1'b0;
        end
        else
        begin
            results_ch.ready <= !throttle || ($urandom_range(99) >= 33);
        end
    end

    task automatic write_window(input logic [CFG_W-1:0] setting);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= setting;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] smp);
        pending_samples.push_back(smp);
        issued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != issued_count || expected_filtered.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] base,
                                                        input logic [SAMPLE_W-1:0] prev);
        int unsigned mode;
        mode = $urandom_range(99);
        if (mode < 25)
        begin
            return SAMPLE_W'($urandom);
        end
        else if (mode < 65)
        begin
            return SAMPLE_W'(32'(base) + $urandom_range(63) - 32'd32);
        end
        else if (mode < 75)
        begin
            return '0;
        end
        else if (mode < 85)
        begin
            return '1;
        end
        return prev;    // repeats give ties on max/min
    endfunction

    initial begin
        logic [CFG_W-1:0]    plan [10];
        logic [CFG_W-1:0]    setting;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] prev;
        plan = '{4'd8, 4'd1, 4'd2, 4'd0, 4'd15, 4'd3, 4'd8, 4'd4, 4'd5, 4'd9};

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = '0;
        samples_ch.valid     = 1'b0;
        samples_ch.sample    = '0;
        results_ch.ready     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: pass-through leaves history alone
        write_window(4'd0);
        queue_sample(16'h0000);
        queue_sample(16'hFFFF);
        queue_sample(16'hA5A5);
        wait_drained();

        // two-sample mean, first against the cleared history
        write_window(4'd1);
        queue_sample(16'hFFFF);
        queue_sample(16'hFFFF);
        queue_sample(16'h0001);
        queue_sample(16'h5A5A);
        wait_drained();

        write_window(4'd2);
        queue_sample(16'h0000);
        queue_sample(16'hFFFF);
        queue_sample(16'h8000);
        wait_drained();

        // full window: max values, then ties
        write_window(4'd8);
        repeat (4) queue_sample(16'hFFFF);
        repeat (3) queue_sample(16'h1234);
        queue_sample(16'h0000);
        wait_drained();

        // settings above the maximum saturate
        write_window(4'd15);
        queue_sample(16'hFFFF);
        queue_sample(16'h0000);
        queue_sample(16'h7FFF);
        wait_drained();
        write_window(4'd9);
        queue_sample(16'h0001);
        wait_drained();

        prev = '0;
        for (int p = 0; p < 14; p++)
        begin
            setting = (p < 10) ? plan[p] : 4'($urandom_range(15));
            base    = SAMPLE_W'($urandom);
            write_window(setting);
            throttle = (p != 0);
            for (int k = 0; k < 125; k++)
            begin
                prev = pick_sample(base, prev);
                queue_sample(prev);
            end
            if (p == 0)
            begin
                hold_requests++;
            end
            wait_drained();
        end

        throttle = 1'b1;
        repeat (60) @(posedge clk);
        if (expected_filtered.size() != 0)
        begin
            $error("filtered: %0d results never arrived", expected_filtered.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/tmsf_pkg.sv
sv/tmsf_if.sv
sv/tmsf_div.sv
sv/trimmed_mean_sample_filter_top.sv
verif/testbench.sv
